[rtl/tema_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tema_pkg;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUB,
    ST_MLO,
    ST_MHI,
    ST_UPD,
    ST_TDIFF,
    ST_TSUM,
    ST_SAT,
    ST_EMIT
  } tema_state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_SUB,
    OP_MLO,
    OP_MHI,
    OP_UPD,
    OP_TDIFF,
    OP_TSUM,
    OP_SAT,
    OP_PUSH
  } dp_op_t;

  // which average of the cascade is being updated
  typedef logic [1:0] stage_t;
  localparam stage_t STG_E1 = 2'd0;
  localparam stage_t STG_E2 = 2'd1;
  localparam stage_t STG_E3 = 2'd2;

  typedef struct packed {
    dp_op_t op;
    stage_t stage;
  } dp_cmd_t;

  // average width, difference width and low slice of the split multiply
  localparam int AVG_BITS    = 48;
  localparam int DIFF_BITS   = AVG_BITS + 1;
  localparam int MUL_LO_BITS = 25;

endpackage

`default_nettype wire

[rtl/tema_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tema_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output tema_pkg::dp_cmd_t      cmd
);

  tema_pkg::tema_state_t state_r, state_nxt;
  tema_pkg::stage_t      stage_r, stage_nxt;
  logic                  primed_r, primed_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tema_pkg::ST_IDLE;
      stage_r     <= tema_pkg::STG_E1;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    stage_nxt  = stage_r;
    primed_nxt = primed_r;
    cmd.op     = tema_pkg::OP_NONE;
    cmd.stage  = stage_r;
    push       = 1'b0;
    case (state_r)
      tema_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = tema_pkg::OP_CAPTURE;
          stage_nxt = tema_pkg::STG_E1;
          state_nxt = primed_r ? tema_pkg::ST_SUB : tema_pkg::ST_LOAD;
        end
      end
      tema_pkg::ST_LOAD: begin
        cmd.op     = tema_pkg::OP_LOAD;
        primed_nxt = 1'b1;
        state_nxt  = tema_pkg::ST_EMIT;
      end
      tema_pkg::ST_SUB: begin
        cmd.op    = tema_pkg::OP_SUB;
        state_nxt = tema_pkg::ST_MLO;
      end
      tema_pkg::ST_MLO: begin
        cmd.op    = tema_pkg::OP_MLO;
        state_nxt = tema_pkg::ST_MHI;
      end
      tema_pkg::ST_MHI: begin
        cmd.op    = tema_pkg::OP_MHI;
        state_nxt = tema_pkg::ST_UPD;
      end
      tema_pkg::ST_UPD: begin
        cmd.op = tema_pkg::OP_UPD;
        case (stage_r)
          tema_pkg::STG_E1: begin
            stage_nxt = tema_pkg::STG_E2;
            state_nxt = tema_pkg::ST_SUB;
          end
          tema_pkg::STG_E2: begin
            stage_nxt = tema_pkg::STG_E3;
            state_nxt = tema_pkg::ST_SUB;
          end
          default: begin
            state_nxt = tema_pkg::ST_TDIFF;
          end
        endcase
      end
      tema_pkg::ST_TDIFF: begin
        cmd.op    = tema_pkg::OP_TDIFF;
        state_nxt = tema_pkg::ST_TSUM;
      end
      tema_pkg::ST_TSUM: begin
        cmd.op    = tema_pkg::OP_TSUM;
        state_nxt = tema_pkg::ST_SAT;
      end
      tema_pkg::ST_SAT: begin
        cmd.op    = tema_pkg::OP_SAT;
        state_nxt = tema_pkg::ST_EMIT;
      end
      tema_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.op    = tema_pkg::OP_PUSH;
          push      = 1'b1;
          state_nxt = tema_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tema_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_tready  = (state_r == tema_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

[rtl/tema_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module tema_dp #(
  parameter int SAMPLE_BITS     = 32,
  parameter int ALPHA_FRAC_BITS = 16,
  parameter int ALPHA_RESET     = 6242
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tema_pkg::dp_cmd_t          cmd,
  input  wire logic [SAMPLE_BITS-1:0]     in_sample,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ALPHA_FRAC_BITS:0]   cfg_wr_data,
  output logic      [SAMPLE_BITS-1:0]     out_sample,
  output logic                            out_sat
);

  localparam int AW    = ALPHA_FRAC_BITS + 1;
  localparam int AVG   = tema_pkg::AVG_BITS;
  localparam int DW    = tema_pkg::DIFF_BITS;
  localparam int LW    = tema_pkg::MUL_LO_BITS;
  localparam int MW    = LW + 1;
  localparam int PW    = MW + AW + 1;
  // accumulator keeps every bit that reaches the average after the shift
  localparam int CW    = AVG + ALPHA_FRAC_BITS;
  localparam int TW    = DW + 3;
  localparam int GUARD = AVG - SAMPLE_BITS;

  localparam logic [AW-1:0]          ALPHA_ONE = AW'(1) << ALPHA_FRAC_BITS;
  localparam logic signed [CW-1:0]   HALF      = CW'(1) << (ALPHA_FRAC_BITS - 1);
  localparam logic signed [TW-1:0]   RND       = TW'((64'd1 << GUARD) >> 1);
  localparam logic [SAMPLE_BITS-1:0] SMAX      = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN      = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic        [AW-1:0]          alpha_r;
  logic        [AW-1:0]          alpha_eff;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic signed [AVG-1:0]         e1_r, e1_nxt;
  logic signed [AVG-1:0]         e2_r, e2_nxt;
  logic signed [AVG-1:0]         e3_r, e3_nxt;
  logic signed [DW-1:0]          diff_r, diff_nxt;
  logic signed [CW-1:0]          acc_r, acc_nxt;
  logic signed [TW-1:0]          t_r, t_nxt;
  logic        [SAMPLE_BITS-1:0] res_r, res_nxt;
  logic                          res_sat_r, res_sat_nxt;
  logic        [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;
  logic                          out_sat_r, out_sat_nxt;

  logic signed [AVG-1:0]         x_scaled;
  logic signed [AVG-1:0]         e_sel;
  logic signed [AVG-1:0]         src_sel;
  logic signed [AVG-1:0]         e_new;
  logic signed [CW-1:0]          acc_shift;
  logic signed [MW-1:0]          mul_a;
  logic signed [AW:0]            mul_b;
  logic signed [PW-1:0]          mul_p;
  logic signed [TW-1:0]          d_ext;
  logic signed [TW-1:0]          t_shift;
  logic                          ovf;

  // smoothing weight, clamped to one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= AW'(ALPHA_RESET);
    end else if (cfg_wr_en) begin
      alpha_r <= cfg_wr_data;
    end
  end

  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  assign x_scaled = AVG'(x_r) <<< GUARD;

  always_comb begin
    case (cmd.stage)
      tema_pkg::STG_E1: begin
        e_sel   = e1_r;
        src_sel = x_scaled;
      end
      tema_pkg::STG_E2: begin
        e_sel   = e2_r;
        src_sel = e1_r;
      end
      default: begin
        e_sel   = e3_r;
        src_sel = e2_r;
      end
    endcase
  end

  // one shared multiplier, difference split in a low and a high slice
  assign mul_a = (cmd.op == tema_pkg::OP_MHI) ? MW'($signed(diff_r[DW-1:LW]))
                                              : $signed({1'b0, diff_r[LW-1:0]});
  assign mul_b = $signed({1'b0, alpha_eff});
  assign mul_p = mul_a * mul_b;

  assign acc_shift = acc_r >>> ALPHA_FRAC_BITS;
  assign e_new     = e_sel + acc_shift[AVG-1:0];

  assign d_ext   = TW'(diff_r);
  assign t_shift = t_r >>> GUARD;
  assign ovf     = !((&t_shift[TW-1:SAMPLE_BITS-1]) || !(|t_shift[TW-1:SAMPLE_BITS-1]));

  always_comb begin
    x_nxt        = x_r;
    e1_nxt       = e1_r;
    e2_nxt       = e2_r;
    e3_nxt       = e3_r;
    diff_nxt     = diff_r;
    acc_nxt      = acc_r;
    t_nxt        = t_r;
    res_nxt      = res_r;
    res_sat_nxt  = res_sat_r;
    out_data_nxt = out_data_r;
    out_sat_nxt  = out_sat_r;
    case (cmd.op)
      tema_pkg::OP_CAPTURE: begin
        x_nxt = in_sample;
      end
      tema_pkg::OP_LOAD: begin
        e1_nxt      = x_scaled;
        e2_nxt      = x_scaled;
        e3_nxt      = x_scaled;
        res_nxt     = x_r;
        res_sat_nxt = 1'b0;
      end
      tema_pkg::OP_SUB: begin
        diff_nxt = DW'(src_sel) - DW'(e_sel);
      end
      tema_pkg::OP_MLO: begin
        acc_nxt = CW'(mul_p) + HALF;
      end
      tema_pkg::OP_MHI: begin
        acc_nxt = acc_r + (CW'(mul_p) <<< LW);
      end
      tema_pkg::OP_UPD: begin
        case (cmd.stage)
          tema_pkg::STG_E1: e1_nxt = e_new;
          tema_pkg::STG_E2: e2_nxt = e_new;
          default:          e3_nxt = e_new;
        endcase
      end
      tema_pkg::OP_TDIFF: begin
        diff_nxt = DW'(e1_r) - DW'(e2_r);
      end
      tema_pkg::OP_TSUM: begin
        t_nxt = (d_ext <<< 1) + d_ext + TW'(e3_r) + RND;
      end
      tema_pkg::OP_SAT: begin
        res_sat_nxt = ovf;
        if (ovf) begin
          res_nxt = t_shift[TW-1] ? SMIN : SMAX;
        end else begin
          res_nxt = t_shift[SAMPLE_BITS-1:0];
        end
      end
      tema_pkg::OP_PUSH: begin
        out_data_nxt = res_r;
        out_sat_nxt  = res_sat_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    e1_r       <= e1_nxt;
    e2_r       <= e2_nxt;
    e3_r       <= e3_nxt;
    diff_r     <= diff_nxt;
    acc_r      <= acc_nxt;
    t_r        <= t_nxt;
    res_r      <= res_nxt;
    res_sat_r  <= res_sat_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_sample = out_data_r;
  assign out_sat    = out_sat_r;

endmodule

`default_nettype wire

[rtl/triple_ema_filter.sv]
// triple exponential moving average over a stream of signed fixed-point samples
//
// in_*  : one sample word per handshake, price_sample in the low SAMPLE_BITS of in_tdata
// out_* : one result word per sample, tema_value in out_tdata, saturated_flag in out_tuser
// cfg_* : smoothing weight alpha in Q1.ALPHA_FRAC_BITS, written whenever cfg_wr_en is high;
//         values above one act as exactly one
//
// the first sample after reset seeds all three averages and comes back unchanged
// through the output register; no new sample is taken until that word is loaded there
// every later sample runs three dependent updates e += alpha*(x - e) through one
// shared multiplier, each as subtract, low-slice product, high-slice product and
// accumulate steps, then combines 3*e1 - 3*e2 + e3 in a difference and a sum step,
// rounds and saturates, then loads the output register before the next sample is taken
// in_tready is high only while the block is idle
// the output register holds a finished word while out_tready is low; the next sample is
// still accepted and processed, and only its final load waits for the register to drain
// reset (rst_n low, synchronous) drops out_tvalid, returns alpha to ALPHA_RESET and
// clears the primed state so the next sample seeds the averages again
`timescale 1ns / 1ps
`default_nettype none

module triple_ema_filter #(
  parameter int SAMPLE_BITS     = 32,
  parameter int ALPHA_FRAC_BITS = 16,
  parameter int ALPHA_RESET     = 6242
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: price_sample [SAMPLE_BITS-1:0], zero padded to bytes
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  // out_tdata: tema_value [SAMPLE_BITS-1:0], zero padded to bytes
  // out_tuser: saturated_flag [0]
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,
  output logic      [0:0]                          out_tuser,
  // alpha register, Q1.ALPHA_FRAC_BITS
  input  wire logic                                cfg_wr_en,
  input  wire logic [ALPHA_FRAC_BITS:0]            cfg_wr_data
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  tema_pkg::dp_cmd_t          cmd;
  logic [SAMPLE_BITS-1:0]     out_sample;
  logic                       out_sat;

  // sequencing: seed or update path, stage counter, output valid
  tema_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // averages, shared multiplier, combine and saturate, output register
  tema_dp #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS),
    .ALPHA_RESET     (ALPHA_RESET)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_sample  (out_sample),
    .out_sat     (out_sat)
  );

  assign out_tdata = DATA_W'(out_sample);
  assign out_tuser = out_sat;

endmodule

`default_nettype wire

[rtl/tema_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module tema_chk #(
  parameter int SAMPLE_BITS = 32
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  input wire logic [0:0]                       out_tuser
);

  localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // reset empties the output and reopens the input
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // one sample at a time: input closes after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second sample taken while busy");

  // a clipped result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[SAMPLE_BITS-1:0] == SMAX) || (out_tdata[SAMPLE_BITS-1:0] == SMIN))
    else $error("saturated flag without a clipped value");

endmodule

bind triple_ema_filter tema_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tema_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

[dv/tb_triple_ema_filter.sv]
`timescale 1ns / 1ps

module tb_triple_ema_filter;

  // block configuration, kept equal to the dut defaults
  localparam int SAMPLE_BITS     = 32;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int ALPHA_RESET     = 6242;
  localparam int GUARD_BITS      = tema_pkg::AVG_BITS - SAMPLE_BITS;

  // alpha codes that mark the corners of the weight register
  localparam logic [16:0] ALPHA_ZERO    = 17'd0;
  localparam logic [16:0] ALPHA_TINY    = 17'd1;
  localparam logic [16:0] ALPHA_HALF    = 17'd32768;
  localparam logic [16:0] ALPHA_ONE     = 17'd65536;
  localparam logic [16:0] ALPHA_OVER    = 17'd65537;
  localparam logic [16:0] ALPHA_TOP     = 17'd131071;
  localparam logic [16:0] ALPHA_DEFAULT = 17'(ALPHA_RESET);

  // sample extremes
  localparam logic [31:0] PRICE_MIN = 32'h8000_0000;
  localparam logic [31:0] PRICE_MAX = 32'h7FFF_FFFF;
  localparam longint      TEMA_MIN  = -(longint'(1) << (SAMPLE_BITS - 1));
  localparam longint      TEMA_MAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

  localparam int RANDOM_ITEMS = 1030;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic {ROW_SAMPLE, ROW_ALPHA} row_kind_t;
  typedef enum logic [1:0] {FEED_ANY, FEED_EXTREME, FEED_WALK, FEED_STEP} feed_mode_t;

  // one result word: tema value and clip flag
  typedef struct packed {
    logic [31:0] tema;
    logic        clipped;
  } tema_word_t;

  // directed row: a sample (with an optional hand-written result) or an alpha write
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic        fixed;
    logic [31:0] want;
    logic        want_clip;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;      // price_sample [31:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // tema_value [31:0]
  logic [0:0]  out_tuser;          // saturated_flag [0]
  logic        cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;

  triple_ema_filter #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS),
    .ALPHA_RESET    (ALPHA_RESET)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: three cascaded averages with guard bits, plus the primed flag
  // ---------------------------------------------------------------------------
  longint      avg_fast;
  longint      avg_mid;
  longint      avg_slow;
  bit          primed = 1'b0;
  logic [16:0] alpha_reg = ALPHA_DEFAULT;

  tema_word_t pending_tema_q[$];

  // e + round_half_up(alpha * (target - e) / 2^frac), product split so it stays in 64 bits
  function automatic longint ema_step(input longint e, input longint target, input longint a);
    longint diff;
    longint whole;
    longint frac;
    diff  = target - e;
    frac  = diff & ((longint'(1) << ALPHA_FRAC_BITS) - 1);
    whole = diff >>> ALPHA_FRAC_BITS;
    return e + a * whole + ((a * frac + (longint'(1) << (ALPHA_FRAC_BITS - 1)))
                            >>> ALPHA_FRAC_BITS);
  endfunction

  function automatic tema_word_t predict_tema(input logic [31:0] price);
    tema_word_t word;
    longint     scaled;
    longint     weight;
    longint     combo;
    longint     rounded;
    scaled = longint'($signed(price)) * (longint'(1) << GUARD_BITS);
    // first sample after reset seeds the cascade and is echoed
    if (!primed) begin
      avg_fast = scaled;
      avg_mid  = scaled;
      avg_slow = scaled;
      primed   = 1'b1;
      word.tema    = price;
      word.clipped = 1'b0;
      return word;
    end
    // weights above one behave as exactly one
    weight   = (alpha_reg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_reg);
    avg_fast = ema_step(avg_fast, scaled, weight);
    avg_mid  = ema_step(avg_mid, avg_fast, weight);
    avg_slow = ema_step(avg_slow, avg_mid, weight);
    combo    = 3 * avg_fast - 3 * avg_mid + avg_slow + (longint'(1) << (GUARD_BITS - 1));
    rounded  = combo >>> GUARD_BITS;
    word.clipped = 1'b1;
    if (rounded > TEMA_MAX)
      rounded = TEMA_MAX;
    else if (rounded < TEMA_MIN)
      rounded = TEMA_MIN;
    else
      word.clipped = 1'b0;
    word.tema = rounded[31:0];
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking against the oldest pending word
  // ---------------------------------------------------------------------------
  int error_count = 0;
  int results_checked = 0;
  int clipped_seen = 0;

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    tema_word_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tema_q.size() == 0) begin
        note_failure($sformatf("unexpected word tema=%h clip=%b", out_tdata, out_tuser[0]));
      end else begin
        due = pending_tema_q.pop_front();
        results_checked++;
        if (out_tuser[0])
          clipped_seen++;
        if (out_tdata !== due.tema)
          note_failure($sformatf("word %0d tema expected %h got %h",
                                 results_checked, due.tema, out_tdata));
        if (out_tuser[0] !== due.clipped)
          note_failure($sformatf("word %0d clip expected %b got %b",
                                 results_checked, due.clipped, out_tuser[0]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any handshake or register write counts as progress
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words still due",
               STALL_LIMIT, pending_tema_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver back-pressure: short ready runs, short stalls, the odd long stall
  // ---------------------------------------------------------------------------
  bit calm = 1'b0;   // phase with no idling on either side
  int ready_run = 0;

  always @(posedge clk) begin
    int pick;
    if (calm) begin
      out_tready <= 1'b1;
    end else if (ready_run > 0) begin
      ready_run--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        out_tready <= 1'b1;
        ready_run  = $urandom_range(0, 6);
      end else if (pick < 92) begin
        out_tready <= 1'b0;
        ready_run  = $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        ready_run  = $urandom_range(10, 40);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  int samples_sent = 0;
  int alpha_writes = 0;

  function automatic int pick_gap();
    int pick;
    if (calm)
      return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return 0;
    if (pick < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one sample word and hold it until it is taken; valid stays high afterwards
  // so a back-to-back word needs no second assignment in the same step
  task automatic send_sample(input logic [31:0] price, input int gap, input bit fixed,
                             input logic [31:0] want, input bit want_clip);
    tema_word_t due;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    due = predict_tema(price);
    // hand-written rows override the predicted word, the predictor still advances
    if (fixed) begin
      due.tema    = want;
      due.clipped = want_clip;
    end
    pending_tema_q.push_back(due);
    in_tvalid <= 1'b1;
    in_tdata  <= price;
    samples_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  // the weight is only changed once every due word has come back
  task automatic write_alpha(input logic [16:0] value);
    in_tvalid <= 1'b0;
    while (pending_tema_q.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    alpha_reg = value;
    alpha_writes++;
    @(posedge clk);
  endtask

  function automatic logic [16:0] pick_alpha();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return ALPHA_ZERO;
          1:       return ALPHA_TINY;
          2:       return ALPHA_ONE;
          3:       return ALPHA_OVER;
          default: return ALPHA_TOP;
        endcase
      end
      1:       return 17'($urandom_range(0, 131071));
      default: return 17'($urandom_range(1000, 60000));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // directed rows: seeding, weight corners, hold, and a step into both clip rails
  // ---------------------------------------------------------------------------
  localparam int DIRECTED_ROWS = 27;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // first sample seeds the cascade and comes back as is
    '{ROW_SAMPLE, PRICE_MIN,     1'b1, PRICE_MIN,     1'b0},
    '{ROW_SAMPLE, PRICE_MAX,     1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h0,         1'b0, 32'h0,         1'b0},
    // weight of one: every average copies its input
    '{ROW_ALPHA,  32'(ALPHA_ONE), 1'b0, 32'h0,        1'b0},
    '{ROW_SAMPLE, PRICE_MAX,     1'b1, PRICE_MAX,     1'b0},
    '{ROW_SAMPLE, PRICE_MIN,     1'b1, PRICE_MIN,     1'b0},
    '{ROW_SAMPLE, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0},
    // weight above one acts as one
    '{ROW_ALPHA,  32'(ALPHA_TOP), 1'b0, 32'h0,        1'b0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
    // weight of zero: averages frozen, output repeats
    '{ROW_ALPHA,  32'(ALPHA_ZERO), 1'b0, 32'h0,       1'b0},
    '{ROW_SAMPLE, PRICE_MAX,     1'b1, 32'hFFFF_FFFF, 1'b0},
    '{ROW_SAMPLE, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF, 1'b0},
    // smallest nonzero weight
    '{ROW_ALPHA,  32'(ALPHA_TINY), 1'b0, 32'h0,       1'b0},
    '{ROW_SAMPLE, PRICE_MAX,     1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, PRICE_MIN,     1'b0, 32'h0,         1'b0},
    // park at the low rail, then step to the top at half weight: overshoot clips high
    '{ROW_ALPHA,  32'(ALPHA_ONE), 1'b0, 32'h0,        1'b0},
    '{ROW_SAMPLE, PRICE_MIN,     1'b1, PRICE_MIN,     1'b0},
    '{ROW_ALPHA,  32'(ALPHA_HALF), 1'b0, 32'h0,       1'b0},
    '{ROW_SAMPLE, PRICE_MAX,     1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, PRICE_MAX,     1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, PRICE_MAX,     1'b0, 32'h0,         1'b0},
    // and the mirror image into the low rail
    '{ROW_ALPHA,  32'(ALPHA_ONE), 1'b0, 32'h0,        1'b0},
    '{ROW_SAMPLE, PRICE_MAX,     1'b1, PRICE_MAX,     1'b0},
    '{ROW_ALPHA,  32'(ALPHA_HALF), 1'b0, 32'h0,       1'b0},
    '{ROW_SAMPLE, PRICE_MIN,     1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, PRICE_MIN,     1'b0, 32'h0,         1'b0},
    // back to the power-on weight
    '{ROW_ALPHA,  32'(ALPHA_DEFAULT), 1'b0, 32'h0,    1'b0}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          directed_samples;
    int          phase_len;
    feed_mode_t  mode;
    logic [31:0] walk_level;
    logic [31:0] step_level;
    logic [31:0] price;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_ALPHA)
        write_alpha(directed_rows[i].value[16:0]);
      else
        send_sample(directed_rows[i].value, pick_gap(), directed_rows[i].fixed,
                    directed_rows[i].want, directed_rows[i].want_clip);
    end
    directed_samples = samples_sent;

    // random phases: new weight, new idling style, one feed pattern each
    while (samples_sent - directed_samples < RANDOM_ITEMS) begin
      write_alpha(pick_alpha());
      calm       = ($urandom_range(0, 4) == 0);
      mode       = feed_mode_t'($urandom_range(0, 3));
      phase_len  = $urandom_range(15, 60);
      walk_level = $urandom;
      step_level = $urandom_range(0, 1) ? PRICE_MAX : PRICE_MIN;
      repeat (phase_len) begin
        case (mode)
          FEED_ANY: price = $urandom;
          FEED_EXTREME: begin
            case ($urandom_range(0, 5))
              0:       price = PRICE_MIN;
              1:       price = PRICE_MAX;
              2:       price = 32'h0;
              3:       price = 32'hFFFF_FFFF;
              4:       price = 32'h1;
              default: price = 32'h1 << $urandom_range(0, 31);
            endcase
          end
          FEED_WALK: begin
            // slow drift with small noise, the usual price trace
            walk_level = walk_level + $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            price      = walk_level;
          end
          default: begin
            // hold a rail, then jump to the other one: drives the overshoot clipping
            if ($urandom_range(0, 4) == 0)
              step_level = ~step_level;
            price = step_level;
          end
        endcase
        send_sample(price, pick_gap(), 1'b0, 32'h0, 1'b0);
      end
    end

    // drain, then give the block time to show any stray word
    in_tvalid <= 1'b0;
    calm = 1'b0;
    while (pending_tema_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d samples (%0d directed) over %0d weight settings",
             samples_sent, directed_samples, alpha_writes);
    $display("checked %0d result words, %0d of them clipped, %0d mismatches",
             results_checked, clipped_seen, error_count);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[triple_ema_filter.f]
rtl/tema_pkg.sv
rtl/tema_ctrl.sv
rtl/tema_dp.sv
rtl/triple_ema_filter.sv
rtl/tema_chk.sv
dv/tb_triple_ema_filter.sv
